// ----- src/lskd_pkg.sv -----
package lskd_pkg;

  // fixed field widths
  localparam int HALF_W  = 5;
  localparam int DEG_W   = 3;
  localparam int LEN_W   = 13;
  localparam int SYM_W   = 8;
  localparam int KV_W    = 32;
  localparam int Q_FRAC  = 24;
  localparam int ACC_W   = 64;
  localparam int MAX_DEG = 7;

  // register reset values
  localparam logic [HALF_W-1:0] HALF_WIDTH_RST = HALF_W'(3);
  localparam logic [DEG_W-1:0]  COUNT_EXP_RST  = DEG_W'(2);
  localparam logic [DEG_W-1:0]  NORM_EXP_RST   = DEG_W'(1);
  localparam logic [LEN_W-1:0]  SEQ_LENGTH_RST = LEN_W'(64);

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_HALF_WIDTH = 2'd0,
    CFG_COUNT_EXP  = 2'd1,
    CFG_NORM_EXP   = 2'd2,
    CFG_SEQ_LENGTH = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SYM_W-1:0] a_sym;
    logic [SYM_W-1:0] b_sym;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [KV_W-1:0] kernel_value;
    logic            length_error;
  } out_t;

endpackage

// ----- src/locality_string_kernel_dot.sv -----
// Locality-improved string kernel over two byte strings streamed as one symbol pair per
// transaction. A pair that completes a full window runs match recount, one multiply per
// power step on a small multiplier plus a final check, triangular weight multiply,
// accumulate, position update and idle before the next transaction is accepted; any other
// pair runs only recount, position update and idle. The pair marked last then runs the
// normalization on one shared shift-add multiplier that handles MUL_W bits of the operand
// per product, one bit per cycle, for count_exp + 1 + 2*norm_exp products, followed by a
// restoring division, a rounding step and the output load. A length mismatch or a string
// shorter than the window skips the normalization, and a saturated result skips the
// division. The result goes into an output register, and the next pair is taken while it
// waits.
module locality_string_kernel_dot
  import lskd_pkg::*;
#(
  parameter int MAX_HALF_WIDTH = 16,
  parameter int MAX_SEQ_LENGTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [LEN_W-1:0]      cfg_data
);

  localparam int WIN_D  = 2 * MAX_HALF_WIDTH - 1;
  localparam int W_W    = $clog2(2 * MAX_HALF_WIDTH);
  localparam int HC_RAW = $clog2(MAX_HALF_WIDTH + 1);
  localparam int HC_W   = (HC_RAW > HALF_W) ? HC_RAW : HALF_W;
  localparam int SQ_RAW = $clog2(MAX_SEQ_LENGTH + 2);
  localparam int SEQ_W  = (SQ_RAW > LEN_W) ? SQ_RAW : LEN_W;
  localparam int CNT_W  = $clog2(WIN_D + 1);
  localparam int TERM_W = MAX_DEG * CNT_W;
  localparam int PROD_W = TERM_W + SEQ_W;
  localparam int NUM_W  = ACC_W + 2;
  localparam int DEN_W  = 2 * SEQ_W + MAX_DEG * W_W;
  localparam int MUL_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int BIG_W  = MAX_DEG * MUL_W + KV_W + 2;
  localparam int MB_W   = $clog2(MUL_W);
  localparam int DIV_W  = $clog2(KV_W + 1);
  localparam int Q_W    = KV_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_COUNT, S_POW, S_TRI, S_ACC, S_POS, S_DEN_W, S_DEN_L,
    S_DPOW, S_NPOW, S_SAT, S_DIV, S_ROUND, S_EMIT, S_MUL
  } state_t;

  state_t              state;
  state_t              ret;
  logic [HALF_W-1:0]   half_width;
  logic [DEG_W-1:0]    count_exp;
  logic [DEG_W-1:0]    norm_exp;
  logic [LEN_W-1:0]    seq_length;
  logic [WIN_D-1:0]    win;
  logic [CNT_W-1:0]    cnt;
  logic [SEQ_W-1:0]    pos;
  logic [ACC_W-1:0]    acc;
  logic                last_q;
  logic [TERM_W-1:0]   term;
  logic [PROD_W-1:0]   prod;
  logic [DEG_W-1:0]    k;
  logic [DEN_W-1:0]    den;
  logic [BIG_W-1:0]    big_r;
  logic [BIG_W-1:0]    big_p;
  logic [BIG_W-1:0]    dreg;
  logic [BIG_W-1:0]    dsh;
  logic [MUL_W-1:0]    mop;
  logic [MB_W-1:0]     mbit;
  logic [DIV_W-1:0]    dbit;
  logic [Q_W-1:0]      q;
  logic                err;

  // effective window from the half width register
  logic [HC_W-1:0]     h_eff;
  logic [HC_W:0]       w_full;
  logic [W_W-1:0]      w_eff;
  logic [SEQ_W-1:0]    w_seq;
  logic [SEQ_W-1:0]    len_seq;
  logic [SEQ_W-1:0]    n_seq;
  logic [SEQ_W-1:0]    j_seq;
  logic [SEQ_W-1:0]    tri_w;
  logic [SEQ_W-1:0]    pos_inc;
  logic                len_ok;
  logic                contrib;
  logic [CNT_W-1:0]    cnt_c;

  always_comb begin
    if (half_width == '0) begin
      h_eff = HC_W'(1);
    end else if (HC_W'(half_width) > HC_W'(MAX_HALF_WIDTH)) begin
      h_eff = HC_W'(MAX_HALF_WIDTH);
    end else begin
      h_eff = HC_W'(half_width);
    end
    w_full  = {h_eff, 1'b0} - (HC_W + 1)'(1);
    w_eff   = w_full[W_W-1:0];
    w_seq   = SEQ_W'(w_eff);
    len_seq = SEQ_W'(seq_length);
    len_ok  = (seq_length != '0) && (len_seq <= SEQ_W'(MAX_SEQ_LENGTH));
    n_seq   = len_seq - w_seq + SEQ_W'(1);
    j_seq   = pos + SEQ_W'(1) - w_seq;
    tri_w   = (j_seq < (n_seq >> 1)) ? j_seq + SEQ_W'(1) : n_seq - j_seq;
    contrib = len_ok && (pos < len_seq) && ((pos + SEQ_W'(1)) >= w_seq);
    pos_inc = (pos < SEQ_W'(MAX_SEQ_LENGTH + 1)) ? pos + SEQ_W'(1) : pos;
  end

  // match count over the active part of the window
  always_comb begin
    cnt_c = '0;
    for (int i = 0; i < WIN_D; i++) begin
      if (i < int'(w_eff)) begin
        cnt_c = cnt_c + CNT_W'(win[i]);
      end
    end
  end

  // per-pair multiplier
  logic [TERM_W+CNT_W-1:0] pow_prod;
  logic [PROD_W-1:0]       tri_prod;
  logic [ACC_W:0]          acc_sum;

  assign pow_prod = {{CNT_W{1'b0}}, term} * {{TERM_W{1'b0}}, cnt};
  assign tri_prod = {{SEQ_W{1'b0}}, term} * {{TERM_W{1'b0}}, tri_w};
  assign acc_sum  = {1'b0, acc} + {{(ACC_W + 1 - PROD_W){1'b0}}, prod};

  // shift-add step of the wide multiplier and division compares
  logic [BIG_W-1:0] mul_sum;
  logic [BIG_W-1:0] dsh_half;
  logic             div_ge;
  logic             sat_ge;
  logic             rnd_ge;

  assign mul_sum  = {big_p[BIG_W-2:0], 1'b0} + (mop[mbit] ? big_r : '0);
  assign dsh_half = dsh >> 1;
  assign div_ge   = big_r >= dsh_half;
  assign sat_ge   = big_r >= dsh;
  assign rnd_ge   = {big_r, 1'b0} >= {1'b0, dreg};

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // sequencer, stream state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      half_width <= HALF_WIDTH_RST;
      count_exp  <= COUNT_EXP_RST;
      norm_exp   <= NORM_EXP_RST;
      seq_length <= SEQ_LENGTH_RST;
      win        <= '0;
      cnt        <= '0;
      pos        <= '0;
      acc        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_HALF_WIDTH: half_width <= cfg_data[HALF_W-1:0];
          CFG_COUNT_EXP:  count_exp  <= cfg_data[DEG_W-1:0];
          CFG_NORM_EXP:   norm_exp   <= cfg_data[DEG_W-1:0];
          CFG_SEQ_LENGTH: seq_length <= cfg_data[LEN_W-1:0];
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            win    <= WIN_D'({win, (in_data.a_sym == in_data.b_sym)});
            last_q <= in_data.last;
            state  <= S_COUNT;
          end
        end

        S_COUNT: begin
          cnt  <= cnt_c;
          term <= TERM_W'(1);
          k    <= '0;
          state <= contrib ? S_POW : S_POS;
        end

        // count raised to count_exp
        S_POW: begin
          if (k < count_exp) begin
            term <= pow_prod[TERM_W-1:0];
            k    <= k + DEG_W'(1);
          end else begin
            state <= S_TRI;
          end
        end

        S_TRI: begin
          prod  <= tri_prod;
          state <= S_ACC;
        end

        S_ACC: begin
          acc   <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
          state <= S_POS;
        end

        S_POS: begin
          pos <= pos_inc;
          if (!last_q) begin
            state <= S_IDLE;
          end else if (!len_ok || pos_inc != len_seq) begin
            q     <= '0;
            err   <= 1'b1;
            state <= S_EMIT;
          end else if (len_seq < w_seq) begin
            q     <= (norm_exp == '0) ? (Q_W'(1) << Q_FRAC) : '0;
            err   <= 1'b0;
            state <= S_EMIT;
          end else begin
            err   <= 1'b0;
            big_r <= BIG_W'(n_seq);
            k     <= '0;
            state <= S_DEN_W;
          end
        end

        // denominator: windows * w^count_exp * length
        S_DEN_W: begin
          big_p <= '0;
          mbit  <= MB_W'(MUL_W - 1);
          state <= S_MUL;
          if (k < count_exp) begin
            mop <= MUL_W'(w_eff);
            k   <= k + DEG_W'(1);
            ret <= S_DEN_W;
          end else begin
            mop <= MUL_W'(len_seq);
            ret <= S_DEN_L;
          end
        end

        S_DEN_L: begin
          den   <= big_r[DEN_W-1:0];
          big_r <= BIG_W'(1);
          k     <= '0;
          state <= S_DPOW;
        end

        S_DPOW: begin
          if (k < norm_exp) begin
            mop   <= MUL_W'(den);
            k     <= k + DEG_W'(1);
            big_p <= '0;
            mbit  <= MB_W'(MUL_W - 1);
            ret   <= S_DPOW;
            state <= S_MUL;
          end else begin
            dreg  <= big_r;
            dsh   <= big_r << (KV_W + 1);
            big_r <= BIG_W'(1);
            k     <= '0;
            state <= S_NPOW;
          end
        end

        S_NPOW: begin
          if (k < norm_exp) begin
            mop   <= MUL_W'({acc, 2'b00});
            k     <= k + DEG_W'(1);
            big_p <= '0;
            mbit  <= MB_W'(MUL_W - 1);
            ret   <= S_NPOW;
            state <= S_MUL;
          end else begin
            big_r <= big_r << Q_FRAC;
            state <= S_SAT;
          end
        end

        S_SAT: begin
          q    <= sat_ge ? Q_W'({KV_W{1'b1}}) : '0;
          dbit <= DIV_W'(KV_W);
          if (sat_ge) begin
            state <= S_EMIT;
          end else begin
            state <= S_DIV;
          end
        end

        // restoring division, one quotient bit per cycle
        S_DIV: begin
          dsh <= dsh_half;
          if (div_ge) begin
            big_r <= big_r - dsh_half;
            q     <= q | (Q_W'(1) << dbit);
          end
          if (dbit == '0) begin
            state <= S_ROUND;
          end else begin
            dbit <= dbit - DIV_W'(1);
          end
        end

        S_ROUND: begin
          if (rnd_ge) begin
            q <= q + Q_W'(1);
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid             <= 1'b1;
            out_data.kernel_value <= (q > Q_W'({KV_W{1'b1}})) ? '1 : q[KV_W-1:0];
            out_data.length_error <= err;
            win                   <= '0;
            pos                   <= '0;
            acc                   <= '0;
            state                 <= S_IDLE;
          end
        end

        // one bit of the multiplier operand per cycle, msb first
        S_MUL: begin
          big_p <= mul_sum;
          if (mbit == '0) begin
            big_r <= mul_sum;
            state <= ret;
          end else begin
            mbit <= mbit - MB_W'(1);
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
